/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the PID regulator.
// Depends on nothing; the clock and reset names clk and arst_n are assumed in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) lbl: assert property (@(posedge clk) \
	prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/pca_pkg.sv */
// Types, widths, codes and helpers of the clamped PID regulator.
// Depends on nothing.
package pca_pkg;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned DT_W    = 31;
	localparam int unsigned ERR_W   = 33;
	localparam int unsigned MCAND_W = 49;
	localparam int unsigned MPLR_W  = 33;
	localparam int unsigned PROD_W  = MCAND_W + 1 + MPLR_W;
	localparam int unsigned SUM_W   = PROD_W + 1;
	localparam int unsigned INTEG_W = 48;
	localparam int unsigned STEP_W  = 49;
	localparam int unsigned CNT_W   = 6;
	localparam int unsigned IDX_W   = 3;

	localparam logic [1:0] LS_WITHIN = 2'd0;
	localparam logic [1:0] LS_MAX    = 2'd1;
	localparam logic [1:0] LS_MIN    = 2'd2;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [IDX_W-1:0] REG_STEP_TIME = 3'd3;
	localparam logic [IDX_W-1:0] REG_DRIVE_MIN = 3'd4;
	localparam logic [IDX_W-1:0] REG_DRIVE_MAX = 3'd5;

	localparam logic signed [INTEG_W-1:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = 48'sh8000_0000_0000;

	typedef logic signed [INTEG_W+1:0] integ_ext_t;

	// Saturate a widened integral value to the 48-bit range.
	function automatic logic signed [INTEG_W-1:0] sat_integ(input integ_ext_t x);
		logic signed [INTEG_W-1:0] r;
		if (x > integ_ext_t'(INTEG_MAX)) begin
			r = INTEG_MAX;
		end else if (x < integ_ext_t'(INTEG_MIN)) begin
			r = INTEG_MIN;
		end else begin
			r = x[INTEG_W-1:0];
		end
		return r;
	endfunction
endpackage

/* rtl/pid_clamped_antiwindup.sv */
// PID regulator in Q16.16 with derivative on measurement and clamping anti-windup.
// Depends on pca_pkg and assert_macros.svh.
// An update item runs four serial products (error times dt, then the P, I and D terms),
// an integral step and a clamp step; the clamp step waits for a free output register.
// A new item is taken only in idle; a clear item is applied when accepted, with no output.
// Reset (arst_n low, asynchronous) restores register defaults and empties the block.
`include "assert_macros.svh"
module pid_clamped_antiwindup (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [pca_pkg::IDX_W-1:0]           cfg_index,
	input  logic [pca_pkg::DATA_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic signed [pca_pkg::DATA_W-1:0]   target,
	input  logic signed [pca_pkg::DATA_W-1:0]   sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pca_pkg::DATA_W-1:0]   drive,
	output logic [1:0]                          limit_status
);
	typedef enum logic [2:0] {
		S_IDLE, S_MUL_DT, S_STEP, S_MUL_P, S_MUL_I, S_MUL_D, S_CLAMP
	} state_t;

	localparam int unsigned HI_W  = pca_pkg::MCAND_W + 1;
	localparam int unsigned LO_W  = pca_pkg::MPLR_W - 1;
	localparam int unsigned OUT_W = pca_pkg::SUM_W - 16;

	state_t state_q;

	// Configuration registers.
	logic signed [pca_pkg::DATA_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic signed [pca_pkg::DATA_W-1:0] drive_min_q, drive_max_q;
	logic [pca_pkg::DT_W-1:0]          step_time_q;
	logic [pca_pkg::DT_W-1:0]          dt_eff;

	// Controller state and per-item registers.
	logic signed [pca_pkg::INTEG_W-1:0] integ_q;
	logic signed [pca_pkg::DATA_W-1:0]  last_q;
	logic signed [pca_pkg::ERR_W-1:0]   err_q;
	logic signed [pca_pkg::STEP_W-1:0]  step_q;
	logic signed [pca_pkg::SUM_W-1:0]   sum_q;
	logic                               out_valid_q;
	logic signed [pca_pkg::DATA_W-1:0]  drive_q;
	logic [1:0]                         status_q;

	// Serial multiplier.
	logic signed [pca_pkg::MCAND_W-1:0] mcand_q;
	logic [pca_pkg::MPLR_W-1:0]         mplr_q;
	logic signed [pca_pkg::PROD_W-1:0]  acc_q;
	logic [pca_pkg::CNT_W-1:0]          mcnt_q;
	logic signed [HI_W:0]               mul_t;
	logic signed [HI_W:0]               mul_add;
	logic signed [pca_pkg::PROD_W-1:0]  acc_nx;
	logic                               mul_last;

	// Serial divider.
	logic [pca_pkg::STEP_W-1:0]         num_q;
	logic [pca_pkg::DT_W-1:0]           rem_q;
	logic [pca_pkg::STEP_W-1:0]         quo_q;
	logic [pca_pkg::CNT_W-1:0]          dcnt_q;
	logic                               div_busy_q;
	logic                               div_neg_q;
	logic [pca_pkg::DT_W:0]             div_trial;
	logic                               div_ge;
	logic signed [pca_pkg::STEP_W-1:0]  deriv;

	// Item-entry and finishing terms.
	logic                               in_accept;
	logic signed [pca_pkg::ERR_W-1:0]   err_in;
	logic signed [pca_pkg::ERR_W-1:0]   diff_in;
	logic [pca_pkg::ERR_W-1:0]          diff_mag;
	logic signed [pca_pkg::STEP_W-1:0]  step_nx;
	logic signed [pca_pkg::INTEG_W-1:0] integ_add;
	logic signed [pca_pkg::INTEG_W-1:0] integ_undo;
	logic signed [OUT_W-1:0]            out_val;
	logic                               above_max;
	logic                               below_min;
	logic                               out_free;

	assign dt_eff    = (step_time_q == '0) ? pca_pkg::DT_W'(1) : step_time_q;
	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign limit_status = status_q;
	assign out_free  = !out_valid_q || out_ready;

	// Error and measurement change of the incoming item.
	assign err_in   = pca_pkg::ERR_W'(target) - pca_pkg::ERR_W'(sample);
	assign diff_in  = pca_pkg::ERR_W'(last_q) - pca_pkg::ERR_W'(sample);
	assign diff_mag = diff_in[pca_pkg::ERR_W-1] ? pca_pkg::ERR_W'(-diff_in)
		: pca_pkg::ERR_W'(diff_in);

	// One shift-add step: add the multiplicand on a set multiplier bit, subtract on
	// the sign bit, then shift the partial product right.
	assign mul_last = (mcnt_q == pca_pkg::CNT_W'(pca_pkg::MPLR_W - 1));
	assign mul_add  = mplr_q[0] ? (HI_W+1)'(mcand_q) : '0;
	assign mul_t    = mul_last
		? (HI_W+1)'($signed(acc_q[pca_pkg::PROD_W-1 -: HI_W])) - mul_add
		: (HI_W+1)'($signed(acc_q[pca_pkg::PROD_W-1 -: HI_W])) + mul_add;
	assign acc_nx   = {mul_t, acc_q[LO_W:1]};

	// Step of the integral: floor of error times dt over 2^16.
	assign step_nx  = acc_nx[pca_pkg::STEP_W+15:16];
	assign integ_add = pca_pkg::sat_integ(pca_pkg::integ_ext_t'(integ_q)
		+ pca_pkg::integ_ext_t'(step_q));
	assign integ_undo = pca_pkg::sat_integ(pca_pkg::integ_ext_t'(integ_q)
		- pca_pkg::integ_ext_t'(step_q));

	// Restoring division, one quotient bit per cycle.
	assign div_trial = {rem_q, num_q[pca_pkg::STEP_W-1]};
	assign div_ge    = (div_trial >= {1'b0, dt_eff});
	assign deriv     = div_neg_q ? pca_pkg::STEP_W'(-$signed(quo_q)) : $signed(quo_q);

	// Clamp decision on the floored sum.
	assign out_val   = sum_q[pca_pkg::SUM_W-1:16];
	assign above_max = out_val > OUT_W'(drive_max_q);
	assign below_min = out_val < OUT_W'(drive_min_q);

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			step_time_q <= pca_pkg::DT_W'(65536);
			drive_min_q <= 32'sh8000_0000;
			drive_max_q <= 32'sh7FFF_FFFF;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pca_pkg::REG_GAIN_P:    gain_p_q    <= cfg_data;
				pca_pkg::REG_GAIN_I:    gain_i_q    <= cfg_data;
				pca_pkg::REG_GAIN_D:    gain_d_q    <= cfg_data;
				pca_pkg::REG_STEP_TIME: step_time_q <= cfg_data[pca_pkg::DT_W-1:0];
				pca_pkg::REG_DRIVE_MIN: drive_min_q <= cfg_data;
				pca_pkg::REG_DRIVE_MAX: drive_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Divider for the derivative, started when an update item enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			dcnt_q     <= '0;
		end else if (in_accept && cmd == pca_pkg::CMD_UPDATE) begin
			div_busy_q <= 1'b1;
			dcnt_q     <= '0;
		end else if (div_busy_q) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (dcnt_q == pca_pkg::CNT_W'(pca_pkg::STEP_W - 1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && cmd == pca_pkg::CMD_UPDATE) begin
			div_neg_q <= diff_in[pca_pkg::ERR_W-1];
			num_q     <= {diff_mag, 16'b0};
			rem_q     <= '0;
			quo_q     <= '0;
		end else if (div_busy_q) begin
			num_q <= {num_q[pca_pkg::STEP_W-2:0], 1'b0};
			rem_q <= div_ge ? pca_pkg::DT_W'(div_trial - {1'b0, dt_eff})
				: div_trial[pca_pkg::DT_W-1:0];
			quo_q <= {quo_q[pca_pkg::STEP_W-2:0], div_ge};
		end
	end

	// Sequencer, multiplier, controller state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			integ_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			mcnt_q      <= '0;
			mcand_q     <= '0;
			mplr_q      <= '0;
			acc_q       <= '0;
			err_q       <= '0;
			step_q      <= '0;
			sum_q       <= '0;
			drive_q     <= '0;
			status_q    <= pca_pkg::LS_WITHIN;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q != S_IDLE && state_q != S_STEP && state_q != S_CLAMP) begin
				acc_q  <= acc_nx;
				mplr_q <= {1'b0, mplr_q[pca_pkg::MPLR_W-1:1]};
				mcnt_q <= mcnt_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (cmd == pca_pkg::CMD_CLEAR) begin
							integ_q <= '0;
							last_q  <= '0;
						end else begin
							err_q   <= err_in;
							last_q  <= sample;
							mcand_q <= pca_pkg::MCAND_W'(err_in);
							mplr_q  <= pca_pkg::MPLR_W'(dt_eff);
							acc_q   <= '0;
							mcnt_q  <= '0;
							state_q <= S_MUL_DT;
						end
					end
				end
				S_MUL_DT: begin
					if (mul_last) begin
						step_q  <= step_nx;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					integ_q <= integ_add;
					sum_q   <= '0;
					mcand_q <= pca_pkg::MCAND_W'(err_q);
					mplr_q  <= pca_pkg::MPLR_W'(gain_p_q);
					acc_q   <= '0;
					mcnt_q  <= '0;
					state_q <= S_MUL_P;
				end
				S_MUL_P: begin
					if (mul_last) begin
						sum_q   <= sum_q + pca_pkg::SUM_W'(acc_nx);
						mcand_q <= pca_pkg::MCAND_W'(integ_q);
						mplr_q  <= pca_pkg::MPLR_W'(gain_i_q);
						acc_q   <= '0;
						mcnt_q  <= '0;
						state_q <= S_MUL_I;
					end
				end
				S_MUL_I: begin
					if (mul_last) begin
						sum_q   <= sum_q + pca_pkg::SUM_W'(acc_nx);
						mcand_q <= deriv;
						mplr_q  <= pca_pkg::MPLR_W'(gain_d_q);
						acc_q   <= '0;
						mcnt_q  <= '0;
						state_q <= S_MUL_D;
					end
				end
				S_MUL_D: begin
					if (mul_last) begin
						sum_q   <= sum_q + pca_pkg::SUM_W'(acc_nx);
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					// Hand the item over once the output register is free.
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (above_max) begin
							drive_q  <= drive_max_q;
							status_q <= pca_pkg::LS_MAX;
							if (err_q > 0) begin
								integ_q <= integ_undo;
							end
						end else if (below_min) begin
							drive_q  <= drive_min_q;
							status_q <= pca_pkg::LS_MIN;
							if (err_q < 0) begin
								integ_q <= integ_undo;
							end
						end else begin
							drive_q  <= out_val[pca_pkg::DATA_W-1:0];
							status_q <= pca_pkg::LS_WITHIN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_div_ready, (state_q == S_MUL_D) |-> !div_busy_q, "divider late")
	`ASSERT_CLK(a_clear_silent, (in_accept && cmd == pca_pkg::CMD_CLEAR && !out_valid_q) |=> !out_valid_q, "clear gave an item")
	`ASSERT_CLK(a_max_value, (out_valid_q && status_q == pca_pkg::LS_MAX) |-> (drive_q == drive_max_q), "bad max clamp")
	`ASSERT_ALWAYS(a_busy_not_ready, (state_q != S_IDLE) |-> !in_ready, "input taken while busy")
endmodule
